@@ rtl/int8_matrix_vector_dot_top_assert.svh @@
// assertion macros for the int8 matrix-vector dot block
// expects clk_i and rst_ni in the scope of each use
`ifndef INT8_MATRIX_VECTOR_DOT_TOP_ASSERT_SVH
`define INT8_MATRIX_VECTOR_DOT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define I8MVD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define I8MVD_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define I8MVD_ASSERT(name, prop, msg)
`define I8MVD_ASSERT_NEVER(name, cond, msg)
`endif

`endif

@@ rtl/i8mvd_pkg.sv @@
// shared types and constants for the int8 matrix-vector dot block
// no dependencies
package i8mvd_pkg;

  localparam int unsigned LANES       = 4;
  localparam int unsigned ELEM_W      = 8;
  localparam int unsigned PROD_W      = 2 * ELEM_W;
  localparam int unsigned ACC_W       = 32;
  localparam int unsigned WORD_W      = LANES * ELEM_W;
  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned PTR_W       = $clog2(STORE_DEPTH);
  localparam int unsigned CHUNK_W     = 11;
  localparam int unsigned MAX_ROWS    = 4096;
  localparam int unsigned ROW_CNT_W   = 13;
  localparam int unsigned ROW_IDX_W   = 12;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // request opcodes
  localparam logic OP_VECTOR = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_COUNT   = 1'b0;
  localparam logic REG_CHUNK_COUNT = 1'b1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [LANES-1:0][PROD_W-1:0] prod_vec_t;

  typedef struct packed {
    logic  op;
    elem_t elem0;
    elem_t elem1;
    elem_t elem2;
    elem_t elem3;
  } in_req_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0]    row_index;
    logic signed [ACC_W-1:0] dot_value;
    logic                    last_row;
  } out_rsp_t;

  // effective (clamped) counts
  typedef struct packed {
    logic [CHUNK_W-1:0]   chunks;
    logic [ROW_CNT_W-1:0] rows;
  } cfg_t;

  // per-request control carried down the pipeline
  typedef struct packed {
    logic                 valid;
    logic                 mac;
    logic                 emit;
    logic                 last;
    logic [ROW_IDX_W-1:0] row_idx;
  } ctl_t;

endpackage

@@ rtl/int8_matrix_vector_dot_top.sv @@
// top level of the int8 matrix-vector dot block
// depends on i8mvd_pkg, i8mvd_ram, i8mvd_lane, i8mvd_merge, i8mvd_cfg and the assert header
//
// Usage: the input channel (in_valid_i/in_ready_o/in_req_i) takes one request per cycle.
// A request with op = vector writes four int8 elements as one chunk into the vector store;
// a request with op = weight multiplies four int8 weights with the stored chunk at the
// column pointer in four parallel lanes and adds the lane sum to the row accumulator.
// After chunk_count weight requests a result (row index, int32 dot value, last-row flag)
// leaves on the output channel (out_valid_o/out_ready_i/out_rsp_o).
// Throughput: one request per cycle while the receiver does not stall. A row's result
// is valid once its final weight request has passed the store read (registered at the
// accept edge), the lane multiply register and the merge into the output register.
// Reset clears pointers, row counter and accumulator and sets both counts to one; the
// vector store is not cleared and must be written before use.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops until the
// output register is taken. Configuration is to be written through the APB-style port
// only while idle; the block itself does not enforce this.
`include "int8_matrix_vector_dot_top_assert.svh"

module int8_matrix_vector_dot_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  i8mvd_pkg::in_req_t                in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output i8mvd_pkg::out_rsp_t               out_rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i8mvd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [i8mvd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [i8mvd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready
);

  i8mvd_pkg::cfg_t                  cfg;
  logic                             adv;
  logic                             accept;
  logic                             is_mac;
  logic [i8mvd_pkg::PTR_W-1:0]      vec_ptr_d, vec_ptr_q;
  logic [i8mvd_pkg::PTR_W-1:0]      col_ptr_d, col_ptr_q;
  logic [i8mvd_pkg::ROW_IDX_W-1:0]  row_cnt_d, row_cnt_q;
  logic [i8mvd_pkg::CHUNK_W-1:0]    vec_inc, col_inc;
  logic [i8mvd_pkg::ROW_CNT_W-1:0]  row_inc;
  logic                             row_done;
  logic                             row_last;
  i8mvd_pkg::ctl_t                  s1_ctl_d, s1_ctl_q, s2_ctl_q;
  i8mvd_pkg::elem_t                 in_elem [i8mvd_pkg::LANES];
  i8mvd_pkg::elem_t                 s1_w_q  [i8mvd_pkg::LANES];
  logic [i8mvd_pkg::WORD_W-1:0]     rd_data;
  i8mvd_pkg::prod_vec_t             prod;

  // configuration registers
  i8mvd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = adv;
  assign accept     = in_valid_i && in_ready_o;
  assign is_mac     = (in_req_i.op == i8mvd_pkg::OP_WEIGHT);

  assign in_elem[0] = in_req_i.elem0;
  assign in_elem[1] = in_req_i.elem1;
  assign in_elem[2] = in_req_i.elem2;
  assign in_elem[3] = in_req_i.elem3;

  // pointer and row bookkeeping at request accept
  assign vec_inc  = {1'b0, vec_ptr_q} + i8mvd_pkg::CHUNK_W'(1);
  assign col_inc  = {1'b0, col_ptr_q} + i8mvd_pkg::CHUNK_W'(1);
  assign row_inc  = {1'b0, row_cnt_q} + i8mvd_pkg::ROW_CNT_W'(1);
  assign row_done = (col_inc >= cfg.chunks);
  assign row_last = (row_inc >= cfg.rows);

  always_comb begin
    vec_ptr_d = vec_ptr_q;
    col_ptr_d = col_ptr_q;
    row_cnt_d = row_cnt_q;
    if (accept && !is_mac) begin
      vec_ptr_d = (vec_inc >= cfg.chunks) ? '0 : vec_inc[i8mvd_pkg::PTR_W-1:0];
    end
    if (accept && is_mac) begin
      col_ptr_d = row_done ? '0 : col_inc[i8mvd_pkg::PTR_W-1:0];
      if (row_done) begin
        row_cnt_d = row_last ? '0 : row_inc[i8mvd_pkg::ROW_IDX_W-1:0];
      end
    end
  end

  // control for the request entering the pipeline
  always_comb begin
    s1_ctl_d.valid   = accept;
    s1_ctl_d.mac     = accept && is_mac;
    s1_ctl_d.emit    = accept && is_mac && row_done;
    s1_ctl_d.last    = row_last;
    s1_ctl_d.row_idx = row_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_ptr_q <= '0;
      col_ptr_q <= '0;
      row_cnt_q <= '0;
      s1_ctl_q  <= '0;
      s2_ctl_q  <= '0;
    end else begin
      vec_ptr_q <= vec_ptr_d;
      col_ptr_q <= col_ptr_d;
      row_cnt_q <= row_cnt_d;
      if (adv) begin
        s1_ctl_q <= s1_ctl_d;
        s2_ctl_q <= s1_ctl_q;
      end
    end
  end

  // weights are registered alongside the store read
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_w_q <= in_elem;
    end
  end

  // vector store: chunk write on vector requests, read on weight requests
  i8mvd_ram #(
    .WIDTH (i8mvd_pkg::WORD_W),
    .DEPTH (i8mvd_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && !is_mac),
    .waddr_i (vec_ptr_q),
    .wdata_i ({in_req_i.elem3, in_req_i.elem2, in_req_i.elem1, in_req_i.elem0}),
    .re_i    (accept && is_mac),
    .raddr_i (col_ptr_q),
    .rdata_o (rd_data)
  );

  // multiply lanes
  for (genvar l = 0; l < i8mvd_pkg::LANES; l++) begin : g_lane
    i8mvd_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .weight_i (s1_w_q[l]),
      .vec_i    (i8mvd_pkg::elem_t'(rd_data[l*i8mvd_pkg::ELEM_W +: i8mvd_pkg::ELEM_W])),
      .prod_o   (prod[l])
    );
  end

  // accumulate and hold the result
  i8mvd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (s2_ctl_q),
    .prod_i      (prod),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  // checks
  `I8MVD_ASSERT_NEVER(a_emit_needs_mac, s1_ctl_q.emit && !s1_ctl_q.mac, "emit on a non-weight request")
  `I8MVD_ASSERT(a_vec_no_result, (s2_ctl_q.valid && !s2_ctl_q.mac && adv) |=> !out_valid_o, "vector request produced a result")
  `I8MVD_ASSERT(a_stall_holds_read, !in_ready_o |=> $stable(rd_data), "store read data moved during stall")

endmodule

@@ rtl/i8mvd_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module i8mvd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/i8mvd_lane.sv @@
// one multiply lane: signed int8 x int8 with registered product
// depends on i8mvd_pkg
module i8mvd_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  i8mvd_pkg::elem_t              weight_i,
  input  i8mvd_pkg::elem_t              vec_i,
  output logic [i8mvd_pkg::PROD_W-1:0]  prod_o
);

  logic signed [i8mvd_pkg::PROD_W-1:0] prod_d;
  logic [i8mvd_pkg::PROD_W-1:0]        prod_q;

  // full-precision signed product
  assign prod_d = weight_i * vec_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/i8mvd_merge.sv @@
// merge stage: sums lane products into the row accumulator, holds output register
// depends on i8mvd_pkg
module i8mvd_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i8mvd_pkg::ctl_t      ctl_i,
  input  i8mvd_pkg::prod_vec_t prod_i,
  input  logic                 out_ready_i,
  output logic                 adv_o,
  output logic                 out_valid_o,
  output i8mvd_pkg::out_rsp_t  out_rsp_o
);

  logic [i8mvd_pkg::ACC_W-1:0] acc_d, acc_q;
  logic [i8mvd_pkg::ACC_W-1:0] sum;
  logic                        out_valid_d, out_valid_q;
  i8mvd_pkg::out_rsp_t         out_rsp_q;
  logic                        take;

  // pipeline moves when the output register is free or being drained
  assign adv_o = !out_valid_q || out_ready_i;
  assign take  = adv_o && ctl_i.valid && ctl_i.mac;

  // add the sign-extended lane products, wrapping at 32 bits
  always_comb begin
    sum = acc_q;
    for (int l = 0; l < i8mvd_pkg::LANES; l++) begin
      sum = sum + {{(i8mvd_pkg::ACC_W - i8mvd_pkg::PROD_W){prod_i[l][i8mvd_pkg::PROD_W-1]}},
                   prod_i[l]};
    end
  end

  // accumulator and output valid next state
  always_comb begin
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    if (take) begin
      acc_d = ctl_i.emit ? '0 : sum;
    end
    if (adv_o) begin
      out_valid_d = take && ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take && ctl_i.emit) begin
      out_rsp_q.row_index <= ctl_i.row_idx;
      out_rsp_q.dot_value <= sum;
      out_rsp_q.last_row  <= ctl_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

@@ rtl/i8mvd_cfg.sv @@
// apb-style configuration registers and clamped effective counts
// depends on i8mvd_pkg
module i8mvd_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [i8mvd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [i8mvd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [i8mvd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready,
  output i8mvd_pkg::cfg_t                    cfg_o
);

  logic [i8mvd_pkg::ROW_CNT_W-1:0] row_count_d, row_count_q;
  logic [i8mvd_pkg::CHUNK_W-1:0]   chunk_count_d, chunk_count_q;
  logic                            wr_en;
  logic                            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // register write
  always_comb begin
    row_count_d   = row_count_q;
    chunk_count_d = chunk_count_q;
    if (wr_en) begin
      unique case (reg_idx)
        i8mvd_pkg::REG_ROW_COUNT:   row_count_d   = pwdata[i8mvd_pkg::ROW_CNT_W-1:0];
        i8mvd_pkg::REG_CHUNK_COUNT: chunk_count_d = pwdata[i8mvd_pkg::CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q   <= i8mvd_pkg::ROW_CNT_W'(1);
      chunk_count_q <= i8mvd_pkg::CHUNK_W'(1);
    end else begin
      row_count_q   <= row_count_d;
      chunk_count_q <= chunk_count_d;
    end
  end

  // register read
  always_comb begin
    unique case (reg_idx)
      i8mvd_pkg::REG_ROW_COUNT:   prdata = i8mvd_pkg::APB_DATA_W'(row_count_q);
      i8mvd_pkg::REG_CHUNK_COUNT: prdata = i8mvd_pkg::APB_DATA_W'(chunk_count_q);
      default:                    prdata = '0;
    endcase
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    priority if (row_count_q == '0) begin
      cfg_o.rows = i8mvd_pkg::ROW_CNT_W'(1);
    end else if (row_count_q > i8mvd_pkg::ROW_CNT_W'(i8mvd_pkg::MAX_ROWS)) begin
      cfg_o.rows = i8mvd_pkg::ROW_CNT_W'(i8mvd_pkg::MAX_ROWS);
    end else begin
      cfg_o.rows = row_count_q;
    end
    priority if (chunk_count_q == '0) begin
      cfg_o.chunks = i8mvd_pkg::CHUNK_W'(1);
    end else if (chunk_count_q > i8mvd_pkg::CHUNK_W'(i8mvd_pkg::STORE_DEPTH)) begin
      cfg_o.chunks = i8mvd_pkg::CHUNK_W'(i8mvd_pkg::STORE_DEPTH);
    end else begin
      cfg_o.chunks = chunk_count_q;
    end
  end

endmodule
